[sv/arta_pkg.sv]
// Package for the AES round transform unit: operation codes and byte transforms.
// Holds the forward and inverse S-box tables and GF(2^8) helpers; no dependencies.
package arta_pkg;

  typedef enum logic [2:0] {
    OP_LOAD      = 3'd0,
    OP_ADD_KEY   = 3'd1,
    OP_SUB       = 3'd2,
    OP_INV_SUB   = 3'd3,
    OP_SHIFT     = 3'd4,
    OP_INV_SHIFT = 3'd5,
    OP_MIX       = 3'd6,
    OP_INV_MIX   = 3'd7
  } op_t;

  localparam logic [7:0] GF_POLY = 8'h1B;

  localparam logic [7:0] SBOX_FWD [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] SBOX_INV [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  // Forward MixColumns on one column word, row 0 in the top byte.
  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] b [4];
    logic [7:0] d [4];
    for (int r = 0; r < 4; r++) b[r] = w[31-8*r -: 8];
    for (int r = 0; r < 4; r++) begin
      d[r] = xtime(b[r]) ^ xtime(b[(r+1)%4]) ^ b[(r+1)%4] ^ b[(r+2)%4] ^ b[(r+3)%4];
    end
    mix_col = {d[0], d[1], d[2], d[3]};
  endfunction

  // Inverse MixColumns: coefficients E, B, D, 9.
  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [7:0] b [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] d [4];
    for (int r = 0; r < 4; r++) begin
      b[r]  = w[31-8*r -: 8];
      x2[r] = xtime(b[r]);
      x4[r] = xtime(x2[r]);
      x8[r] = xtime(x4[r]);
      m9[r] = x8[r] ^ b[r];
      mb[r] = x8[r] ^ x2[r] ^ b[r];
      md[r] = x8[r] ^ x4[r] ^ b[r];
      me[r] = x8[r] ^ x4[r] ^ x2[r];
    end
    for (int r = 0; r < 4; r++) begin
      d[r] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
    end
    inv_mix_col = {d[0], d[1], d[2], d[3]};
  endfunction

endpackage

[sv/arta_datapath.sv]
// Next-state logic of the AES round transform unit: one operation on the 128-bit state.
// Depends on arta_pkg for operation codes, S-boxes and MixColumns helpers.
module arta_datapath (
  input  logic [127:0] cur,        // column 0 in bits 127..96
  input  logic [2:0]   operation,
  input  logic         half_select,
  input  logic [63:0]  data_word,
  output logic [127:0] nxt
);

  logic [7:0] s  [16];  // s[4*c+r]
  logic [7:0] o  [16];
  logic [127:0] mixed;
  logic [127:0] inv_mixed;

  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = cur[127-8*i -: 8];
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mixed[127-32*c -: 32]     = arta_pkg::mix_col(cur[127-32*c -: 32]);
      inv_mixed[127-32*c -: 32] = arta_pkg::inv_mix_col(cur[127-32*c -: 32]);
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) o[i] = s[i];
    nxt = cur;
    case (arta_pkg::op_t'(operation))
      arta_pkg::OP_LOAD: begin
        if (half_select) nxt[63:0] = data_word;
        else             nxt[127:64] = data_word;
      end
      arta_pkg::OP_ADD_KEY: begin
        if (half_select) nxt[63:0] = cur[63:0] ^ data_word;
        else             nxt[127:64] = cur[127:64] ^ data_word;
      end
      arta_pkg::OP_SUB: begin
        for (int i = 0; i < 16; i++) nxt[127-8*i -: 8] = arta_pkg::SBOX_FWD[s[i]];
      end
      arta_pkg::OP_INV_SUB: begin
        for (int i = 0; i < 16; i++) nxt[127-8*i -: 8] = arta_pkg::SBOX_INV[s[i]];
      end
      arta_pkg::OP_SHIFT: begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) o[4*c+r] = s[4*((c+r)%4)+r];
        for (int i = 0; i < 16; i++) nxt[127-8*i -: 8] = o[i];
      end
      arta_pkg::OP_INV_SHIFT: begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) o[4*c+r] = s[4*((c+4-r)%4)+r];
        for (int i = 0; i < 16; i++) nxt[127-8*i -: 8] = o[i];
      end
      arta_pkg::OP_MIX:     nxt = mixed;
      arta_pkg::OP_INV_MIX: nxt = inv_mixed;
      default:              nxt = cur;
    endcase
  end

endmodule

[sv/aes_round_transform_unit.sv]
// AES round transform unit: each accepted input beat gives a registered result beat in the
// next cycle. Throughput one beat per cycle unless the output stalls; the state register
// updates on each accepted beat and a one-entry output register holds the result, so input
// is taken while that slot is free or being drained in the same cycle.
// Synchronous active-high rst clears the state to zero and empties the output slot.
// Depends on arta_pkg and arta_datapath.
module aes_round_transform_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [71:0]   s_axis_tdata,   // [2:0] operation, [3] half_select,
                                        // [67:4] data_word, [71:68] must be zero, not checked
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata    // [63:0] state_upper, [127:64] state_lower
);

  logic [127:0] state;       // column 0 in the top word
  logic [127:0] state_next;
  logic         out_valid;
  logic [127:0] out_data;

  // Accept whenever the output slot is empty or drains this cycle.
  assign s_axis_tready = !out_valid || m_axis_tready;

  arta_datapath u_dp (
    .cur         (state),
    .operation   (s_axis_tdata[2:0]),
    .half_select (s_axis_tdata[3]),
    .data_word   (s_axis_tdata[67:4]),
    .nxt         (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: upper half is columns 2,3, lower half columns 0,1.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      out_data <= {state_next[63:0], state_next[127:64]};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

[sv/aes_round_transform_unit_checker.sv]
// Port checker for the AES round transform unit, bound to the top level.
// Depends only on the top level's ports.
module aes_round_transform_unit_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output slot");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind aes_round_transform_unit aes_round_transform_unit_checker u_chk (.*);
